[rtl/mme_pkg.sv]
// Shared types and constants for the matrix multiply engine.
// No dependencies; used by the core, the MAC datapath and the checker.
`timescale 1ns / 1ps

package mme_pkg;

    // Fixed field widths
    localparam int ELEM_W  = 16;   // Q8.8 element
    localparam int PROD_W  = 32;   // Q16.16 single product
    localparam int ACC_W   = 35;   // Q19.16 dot product
    localparam int IDX_W   = 3;    // row / column index fields
    localparam int DIM_W   = 4;    // size registers
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Size register reset value
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // Item action codes
    typedef enum logic [1:0] {
        ACT_LOAD_A  = 2'd0,
        ACT_LOAD_B  = 2'd1,
        ACT_COMPUTE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // Configuration register indexes (word address)
    typedef enum logic [1:0] {
        REG_ROWS_M  = 2'd0,
        REG_INNER_K = 2'd1,
        REG_COLS_N  = 2'd2,
        REG_UNUSED  = 2'd3
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    // Control tag that travels with each multiply-accumulate step
    typedef struct packed {
        logic             valid;
        logic             first;      // first term of a dot product
        logic             last_k;     // final term of a dot product
        logic             last_elem;  // final element of the result matrix
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } mac_tag_t;

endpackage

[rtl/matrix_multiply_engine_core.sv]
// A load item never raises busy, so a load may follow every cycle. A compute item
// walks its dot products in turn, at a pace set by the single read port of each element
// store feeding one multiply-accumulate unit, and busy stays high through its final
// result. Results cannot be stalled. Reset clears the size registers to 8 and the
// sequencer; the element stores are not cleared and must be loaded before use.
`timescale 1ns / 1ps

module matrix_multiply_engine_core
#(
    parameter int MAX_DIM = 8
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // APB configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mme_pkg::PADDR_W-1:0]           paddr,
    input  logic [mme_pkg::PDATA_W-1:0]           pwdata,
    output logic [mme_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready,
    // Item command
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            action,
    input  logic [mme_pkg::IDX_W-1:0]             row_index,
    input  logic [mme_pkg::IDX_W-1:0]             col_index,
    input  logic signed [mme_pkg::ELEM_W-1:0]     element_value,
    // Results
    output logic                                  out_valid,
    output logic [mme_pkg::IDX_W-1:0]             out_row,
    output logic [mme_pkg::IDX_W-1:0]             out_col,
    output logic signed [mme_pkg::ACC_W-1:0]      product_value,
    output logic                                  last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_DIM);

    // Configuration
    logic [mme_pkg::DIM_W-1:0] rows_m_reg;
    logic [mme_pkg::DIM_W-1:0] inner_k_reg;
    logic [mme_pkg::DIM_W-1:0] cols_n_reg;
    logic                      cfg_wr;
    mme_pkg::reg_idx_t         cfg_idx;

    // Sequencer
    mme_pkg::state_t state_reg;
    mme_pkg::state_t state_next;
    logic [IW-1:0]   i_reg, i_next;
    logic [IW-1:0]   j_reg, j_next;
    logic [IW-1:0]   t_reg, t_next;
    logic [IW-1:0]   mm1_reg, mm1_next;
    logic [IW-1:0]   km1_reg, km1_next;
    logic [IW-1:0]   nm1_reg, nm1_next;
    logic [IW-1:0]   mm1_eff, km1_eff, nm1_eff;
    logic            accept;
    logic            t_end, j_end, i_end;

    // Stores
    logic [mme_pkg::ELEM_W-1:0] a_mem [DEPTH];
    logic [mme_pkg::ELEM_W-1:0] b_mem [DEPTH];
    logic [mme_pkg::ELEM_W-1:0] a_rd_reg;
    logic [mme_pkg::ELEM_W-1:0] b_rd_reg;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              a_rd_addr;
    logic [AW-1:0]              b_rd_addr;
    logic                       wr_in_range;
    logic                       a_we, b_we;
    mme_pkg::mac_tag_t          issue_tag;
    mme_pkg::mac_tag_t          rd_tag_reg;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = mme_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg  <= mme_pkg::DIM_RESET;
            inner_k_reg <= mme_pkg::DIM_RESET;
            cols_n_reg  <= mme_pkg::DIM_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                mme_pkg::REG_ROWS_M:  rows_m_reg  <= pwdata[mme_pkg::DIM_W-1:0];
                mme_pkg::REG_INNER_K: inner_k_reg <= pwdata[mme_pkg::DIM_W-1:0];
                mme_pkg::REG_COLS_N:  cols_n_reg  <= pwdata[mme_pkg::DIM_W-1:0];
                default:              ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (cfg_idx)
            mme_pkg::REG_ROWS_M:  prdata = mme_pkg::PDATA_W'(rows_m_reg);
            mme_pkg::REG_INNER_K: prdata = mme_pkg::PDATA_W'(inner_k_reg);
            mme_pkg::REG_COLS_N:  prdata = mme_pkg::PDATA_W'(cols_n_reg);
            default:              prdata = '0;
        endcase
    end

    // Effective sizes minus one: zero acts as one, oversize clamps to MAX_DIM
    function automatic logic [IW-1:0] dim_m1(input logic [mme_pkg::DIM_W-1:0] dim);
        logic [IW-1:0] r;
        if (dim == '0)
        begin
            r = '0;
        end
        else if (int'(dim) > MAX_DIM)
        begin
            r = IW'(MAX_DIM - 1);
        end
        else
        begin
            r = IW'(dim - mme_pkg::DIM_W'(1));
        end
        return r;
    endfunction

    assign mm1_eff = dim_m1(rows_m_reg);
    assign km1_eff = dim_m1(inner_k_reg);
    assign nm1_eff = dim_m1(cols_n_reg);

    // ---------------- sequencer ----------------
    assign busy   = (state_reg != mme_pkg::ST_IDLE);
    assign accept = start & ~busy;
    assign t_end  = (t_reg == km1_reg);
    assign j_end  = (j_reg == nm1_reg);
    assign i_end  = (i_reg == mm1_reg);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        t_next     = t_reg;
        mm1_next   = mm1_reg;
        km1_next   = km1_reg;
        nm1_next   = nm1_reg;
        unique case (state_reg)
            mme_pkg::ST_IDLE:
            begin
                if (accept && action == mme_pkg::ACT_COMPUTE)
                begin
                    state_next = mme_pkg::ST_ISSUE;
                    i_next     = '0;
                    j_next     = '0;
                    t_next     = '0;
                    mm1_next   = mm1_eff;
                    km1_next   = km1_eff;
                    nm1_next   = nm1_eff;
                end
            end
            mme_pkg::ST_ISSUE:
            begin
                // Walk t innermost, then j, then i
                if (!t_end)
                begin
                    t_next = t_reg + IW'(1);
                end
                else
                begin
                    t_next = '0;
                    if (!j_end)
                    begin
                        j_next = j_reg + IW'(1);
                    end
                    else
                    begin
                        j_next = '0;
                        if (i_end)
                        begin
                            state_next = mme_pkg::ST_DRAIN;
                        end
                        else
                        begin
                            i_next = i_reg + IW'(1);
                        end
                    end
                end
            end
            mme_pkg::ST_DRAIN:
            begin
                if (out_valid && last)
                begin
                    state_next = mme_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mme_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mme_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            t_reg     <= '0;
            mm1_reg   <= '0;
            km1_reg   <= '0;
            nm1_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            t_reg     <= t_next;
            mm1_reg   <= mm1_next;
            km1_reg   <= km1_next;
            nm1_reg   <= nm1_next;
        end
    end

    // ---------------- element stores ----------------
    assign wr_in_range = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
    assign wr_addr     = AW'(int'(row_index) * MAX_DIM + int'(col_index));
    assign a_we        = accept && action == mme_pkg::ACT_LOAD_A && wr_in_range;
    assign b_we        = accept && action == mme_pkg::ACT_LOAD_B && wr_in_range;
    assign a_rd_addr   = AW'(int'(i_reg) * MAX_DIM + int'(t_reg));
    assign b_rd_addr   = AW'(int'(t_reg) * MAX_DIM + int'(j_reg));

    // Loads and compute reads never overlap: loads are only taken while idle
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[wr_addr] <= element_value;
        end
        a_rd_reg <= a_mem[a_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[wr_addr] <= element_value;
        end
        b_rd_reg <= b_mem[b_rd_addr];
    end

    // Tag for the step being read this cycle
    always_comb
    begin
        issue_tag.valid     = (state_reg == mme_pkg::ST_ISSUE);
        issue_tag.first     = (t_reg == '0);
        issue_tag.last_k    = t_end;
        issue_tag.last_elem = t_end & j_end & i_end;
        issue_tag.row       = mme_pkg::IDX_W'(i_reg);
        issue_tag.col       = mme_pkg::IDX_W'(j_reg);
    end

    // Tag follows the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_tag_reg <= '0;
        end
        else
        begin
            rd_tag_reg <= issue_tag;
        end
    end

    // ---------------- multiply-accumulate ----------------
    mme_mac u_mac
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .tag_in        (rd_tag_reg),
        .a_data        (a_rd_reg),
        .b_data        (b_rd_reg),
        .out_valid     (out_valid),
        .last          (last),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value)
    );

endmodule

[rtl/mme_mac.sv]
// Multiply-accumulate datapath: registered 16x16 product, then 35-bit accumulation.
// Depends on mme_pkg for widths and the step tag struct.
`timescale 1ns / 1ps

module mme_mac
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mme_pkg::mac_tag_t                    tag_in,
    input  logic signed [mme_pkg::ELEM_W-1:0]    a_data,
    input  logic signed [mme_pkg::ELEM_W-1:0]    b_data,
    output logic                                 out_valid,
    output logic                                 last,
    output logic [mme_pkg::IDX_W-1:0]            out_row,
    output logic [mme_pkg::IDX_W-1:0]            out_col,
    output logic signed [mme_pkg::ACC_W-1:0]     product_value
);

    mme_pkg::mac_tag_t                   prod_tag_reg;
    mme_pkg::mac_tag_t                   acc_tag_reg;
    logic signed [mme_pkg::PROD_W-1:0]   prod_reg;
    logic signed [mme_pkg::PROD_W-1:0]   prod_next;
    logic signed [mme_pkg::ACC_W-1:0]    acc_reg;
    logic signed [mme_pkg::ACC_W-1:0]    acc_next;

    // Product stage
    assign prod_next = a_data * b_data;

    // Accumulate stage: restart on the first term of each dot product
    always_comb
    begin
        if (prod_tag_reg.first)
        begin
            acc_next = mme_pkg::ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg + mme_pkg::ACC_W'(prod_reg);
        end
    end

    // Step tags, registered alongside each stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_tag_reg <= '0;
            acc_tag_reg  <= '0;
        end
        else
        begin
            prod_tag_reg <= tag_in;
            acc_tag_reg  <= prod_tag_reg;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (prod_tag_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    // A result is shown once its final term has been added
    assign out_valid     = acc_tag_reg.valid & acc_tag_reg.last_k;
    assign last          = acc_tag_reg.last_elem;
    assign out_row       = acc_tag_reg.row;
    assign out_col       = acc_tag_reg.col;
    assign product_value = acc_reg;

endmodule

[rtl/mme_checker.sv]
// Port-level checks on the matrix multiply engine, bound to the top level.
// Depends on mme_pkg for the action codes.
`timescale 1ns / 1ps

module mme_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [1:0]                   action,
    input logic                         out_valid,
    input logic                         last
);

    // Results only appear while a compute item is in flight
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("result shown while not busy");

    // A taken compute item holds off further items
    a_compute_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == mme_pkg::ACT_COMPUTE) |=> busy)
        else $error("compute item did not raise busy");

    // Load and ignored items never stall the port
    a_load_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action != mme_pkg::ACT_COMPUTE) |=> !busy)
        else $error("non-compute item raised busy");

    // The final result frees the block
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |=> !busy)
        else $error("busy held after final result");

    // Busy only rises on a taken compute item
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && action == mme_pkg::ACT_COMPUTE))
        else $error("busy rose without a compute item");

endmodule

bind matrix_multiply_engine_core mme_checker u_mme_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .out_valid (out_valid),
    .last      (last)
);

[tb/matrix_multiply_engine_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for matrix_multiply_engine_core: element loads, computes and
// size-register writes, with every emitted product element checked in order.
// Depends on mme_pkg and the core RTL only.

module matrix_multiply_engine_core_tb;

    localparam int DIM_MAX     = 8;
    localparam int CMD_TARGET  = 360;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYC  = 6;     // last result to end of a compute, with margin

    typedef struct {
        mme_pkg::action_t           act;
        logic [mme_pkg::IDX_W-1:0]  row;
        logic [mme_pkg::IDX_W-1:0]  col;
        logic [mme_pkg::ELEM_W-1:0] value;
    } mme_cmd_t;

    typedef struct {
        logic [mme_pkg::IDX_W-1:0]        row;
        logic [mme_pkg::IDX_W-1:0]        col;
        logic signed [mme_pkg::ACC_W-1:0] value;
        logic                             last;
    } product_t;

    // DUT connections, all known from time zero
    logic                              clk           = 1'b0;
    logic                              rst_n         = 1'b0;
    logic                              psel          = 1'b0;
    logic                              penable       = 1'b0;
    logic                              pwrite        = 1'b0;
    logic [mme_pkg::PADDR_W-1:0]       paddr         = '0;
    logic [mme_pkg::PDATA_W-1:0]       pwdata        = '0;
    logic [mme_pkg::PDATA_W-1:0]       prdata;
    logic                              pready;
    logic                              start         = 1'b0;
    logic                              busy;
    logic [1:0]                        action        = mme_pkg::ACT_NONE;
    logic [mme_pkg::IDX_W-1:0]         row_index     = '0;
    logic [mme_pkg::IDX_W-1:0]         col_index     = '0;
    logic signed [mme_pkg::ELEM_W-1:0] element_value = '0;
    logic                              out_valid;
    logic [mme_pkg::IDX_W-1:0]         out_row;
    logic [mme_pkg::IDX_W-1:0]         out_col;
    logic signed [mme_pkg::ACC_W-1:0]  product_value;
    logic                              last;

    // Items waiting for the driver, products waiting for the DUT
    mme_cmd_t cmd_queue[$];
    product_t product_fifo[$];

    // Predictor copy of the element stores and size registers
    logic signed [mme_pkg::ELEM_W-1:0] a_elems [DIM_MAX][DIM_MAX];
    logic signed [mme_pkg::ELEM_W-1:0] b_elems [DIM_MAX][DIM_MAX];
    logic [mme_pkg::DIM_W-1:0]         dim_reg [3] =
        '{mme_pkg::DIM_RESET, mme_pkg::DIM_RESET, mme_pkg::DIM_RESET};

    // Entries the stimulus has already loaded
    bit a_loaded [DIM_MAX][DIM_MAX];
    bit b_loaded [DIM_MAX][DIM_MAX];

    int err_count      = 0;
    int cmds_queued    = 0;
    int loads_taken    = 0;
    int computes_taken = 0;
    int results_seen   = 0;
    int size_writes    = 0;
    int cycle_count    = 0;
    int gap_left       = 0;
    int burst_left     = 0;

    matrix_multiply_engine_core #(
        .MAX_DIM       (DIM_MAX)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .last          (last)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Size register as the hardware uses it: zero acts as 1, large values clamp
    function automatic int used_dim(input logic [mme_pkg::DIM_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > DIM_MAX)
            return DIM_MAX;
        return int'(r);
    endfunction

    function automatic void check_field(input string name, input logic signed [63:0] exp_v,
                                        input logic signed [63:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    // Apply one taken item to the store copy; a compute queues the whole product matrix
    function automatic void apply_matrix_item(input mme_pkg::action_t act,
                                              input logic [mme_pkg::IDX_W-1:0] r,
                                              input logic [mme_pkg::IDX_W-1:0] c,
                                              input logic signed [mme_pkg::ELEM_W-1:0] v);
        int       m;
        int       k;
        int       n;
        longint   acc;
        product_t p;
        case (act)
            mme_pkg::ACT_LOAD_A: a_elems[r][c] = v;
            mme_pkg::ACT_LOAD_B: b_elems[r][c] = v;
            mme_pkg::ACT_COMPUTE:
            begin
                m = used_dim(dim_reg[mme_pkg::REG_ROWS_M]);
                k = used_dim(dim_reg[mme_pkg::REG_INNER_K]);
                n = used_dim(dim_reg[mme_pkg::REG_COLS_N]);
                for (int i = 0; i < m; i++)
                begin
                    for (int j = 0; j < n; j++)
                    begin
                        acc = 0;
                        for (int t = 0; t < k; t++)
                            acc += longint'(a_elems[i][t]) * longint'(b_elems[t][j]);
                        p.row   = mme_pkg::IDX_W'(i);
                        p.col   = mme_pkg::IDX_W'(j);
                        p.value = acc[mme_pkg::ACC_W-1:0];
                        p.last  = (i == m - 1) && (j == n - 1);
                        product_fifo.push_back(p);
                    end
                end
            end
            default: ;  // no-op action
        endcase
    endfunction

    // Element values leaning toward the extremes
    function automatic logic [mme_pkg::ELEM_W-1:0] rand_elem();
        int r = $urandom_range(0, 19);
        if (r < 2)
            return 16'h8000;
        if (r < 4)
            return 16'h7FFF;
        if (r == 4)
            return 16'h0000;
        if (r == 5)
            return 16'hFFFF;
        return mme_pkg::ELEM_W'($urandom);
    endfunction

    // Mostly small sizes, some full size, a few zero or out of range
    function automatic logic [mme_pkg::DIM_W-1:0] rand_size();
        int r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return mme_pkg::DIM_W'($urandom_range(9, 15));
        if (r < 4)
            return mme_pkg::DIM_W'(DIM_MAX);
        return mme_pkg::DIM_W'($urandom_range(1, 4));
    endfunction

    function automatic void push_cmd(input mme_pkg::action_t act, input int r, input int c,
                                     input logic [mme_pkg::ELEM_W-1:0] v);
        mme_cmd_t cmd;
        cmd.act   = act;
        cmd.row   = mme_pkg::IDX_W'(r);
        cmd.col   = mme_pkg::IDX_W'(c);
        cmd.value = v;
        cmd_queue.push_back(cmd);
        if (act == mme_pkg::ACT_LOAD_A)
            a_loaded[r][c] = 1'b1;
        if (act == mme_pkg::ACT_LOAD_B)
            b_loaded[r][c] = 1'b1;
        if (act != mme_pkg::ACT_NONE)
            cmds_queued++;
    endfunction

    // Compute preceded by loads of any entry it would read that was never written
    function automatic void push_compute();
        int m = used_dim(dim_reg[mme_pkg::REG_ROWS_M]);
        int k = used_dim(dim_reg[mme_pkg::REG_INNER_K]);
        int n = used_dim(dim_reg[mme_pkg::REG_COLS_N]);
        for (int i = 0; i < m; i++)
            for (int t = 0; t < k; t++)
                if (!a_loaded[i][t])
                    push_cmd(mme_pkg::ACT_LOAD_A, i, t, rand_elem());
        for (int t = 0; t < k; t++)
            for (int j = 0; j < n; j++)
                if (!b_loaded[t][j])
                    push_cmd(mme_pkg::ACT_LOAD_B, t, j, rand_elem());
        push_cmd(mme_pkg::ACT_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
                 mme_pkg::ELEM_W'($urandom));
    endfunction

    // Gap after each item: mostly none, some short, a few long, occasional bursts
    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic apb_xfer(input logic wr, input logic [mme_pkg::PADDR_W-1:0] addr,
                            input logic [mme_pkg::PDATA_W-1:0] wdata,
                            output logic [mme_pkg::PDATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a size register with junk in the unused bits, then read it back unless it is the unused index
    task automatic set_size(input mme_pkg::reg_idx_t idx, input logic [mme_pkg::DIM_W-1:0] v);
        logic [mme_pkg::PDATA_W-1:0] wd;
        logic [mme_pkg::PDATA_W-1:0] rd;
        wd = $urandom;
        wd[mme_pkg::DIM_W-1:0] = v;
        apb_xfer(1'b1, {idx, 2'b00}, wd, rd);
        size_writes++;
        if (idx != mme_pkg::REG_UNUSED)
        begin
            dim_reg[idx] = v;
            apb_xfer(1'b0, {idx, 2'b00}, '0, rd);
            check_field("size register", dim_reg[idx], rd[mme_pkg::DIM_W-1:0]);
        end
    endtask

    // Block fully idle: nothing queued, nothing in flight, then let the tail settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_queue.size() != 0 || start || busy || product_fifo.size() != 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Item driver
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        mme_cmd_t cmd;
        if (!rst_n)
        begin
            start         <= 1'b0;
            action        <= mme_pkg::ACT_NONE;
            row_index     <= '0;
            col_index     <= '0;
            element_value <= '0;
            gap_left = 0;
        end
        else if (!(start && busy))
        begin
            if (start)
                gap_left = pick_gap();
            if (gap_left == 0 && cmd_queue.size() > 0)
            begin
                cmd = cmd_queue.pop_front();
                start         <= 1'b1;
                action        <= cmd.act;
                row_index     <= cmd.row;
                col_index     <= cmd.col;
                element_value <= cmd.value;
            end
            else
            begin
                if (gap_left > 0)
                    gap_left--;
                // idle: fields carry junk
                start         <= 1'b0;
                action        <= 2'($urandom);
                row_index     <= mme_pkg::IDX_W'($urandom);
                col_index     <= mme_pkg::IDX_W'($urandom);
                element_value <= mme_pkg::ELEM_W'($urandom);
            end
        end
    end

    // Result checker, then prediction for the item taken at this edge
    always @(posedge clk)
    begin : monitor_proc
        product_t exp_p;
        if (rst_n)
        begin
            if (out_valid)
            begin
                if (product_fifo.size() == 0)
                begin
                    $error("product at row %0d col %0d with nothing expected", out_row, out_col);
                    err_count++;
                end
                else
                begin
                    exp_p = product_fifo.pop_front();
                    results_seen++;
                    check_field("out_row", exp_p.row, out_row);
                    check_field("out_col", exp_p.col, out_col);
                    check_field("product_value", exp_p.value, product_value);
                    check_field("last", exp_p.last, last);
                end
            end
            if (start && !busy)
            begin
                apply_matrix_item(mme_pkg::action_t'(action), row_index, col_index,
                                  element_value);
                if (action == mme_pkg::ACT_COMPUTE)
                    computes_taken++;
                else if (action != mme_pkg::ACT_NONE)
                    loads_taken++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int                          phase;
        int                          r;
        int                          m;
        int                          k;
        int                          n;
        logic [mme_pkg::PDATA_W-1:0] rd;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Size registers come out of reset at their default
        for (int i = 0; i < 3; i++)
        begin
            apb_xfer(1'b0, {mme_pkg::reg_idx_t'(i), 2'b00}, '0, rd);
            check_field("size register reset", dim_reg[i], rd[mme_pkg::DIM_W-1:0]);
        end

        // Directed: longest dot product of the most negative values, largest sum
        set_size(mme_pkg::REG_ROWS_M, 4'd1);
        set_size(mme_pkg::REG_INNER_K, 4'd8);
        set_size(mme_pkg::REG_COLS_N, 4'd1);
        for (int t = 0; t < DIM_MAX; t++)
        begin
            push_cmd(mme_pkg::ACT_LOAD_A, 0, t, 16'h8000);
            push_cmd(mme_pkg::ACT_LOAD_B, t, 0, 16'h8000);
        end
        push_compute();
        // Mixed extremes, no-op items that must leave the stores alone, far corner
        push_cmd(mme_pkg::ACT_LOAD_A, 0, 0, 16'h7FFF);
        push_cmd(mme_pkg::ACT_LOAD_B, 3, 0, 16'hFFFF);
        push_cmd(mme_pkg::ACT_LOAD_A, 0, 5, 16'h0000);
        push_cmd(mme_pkg::ACT_NONE, 0, 1, 16'h1234);
        push_cmd(mme_pkg::ACT_NONE, 7, 7, 16'hFFFF);
        push_cmd(mme_pkg::ACT_LOAD_A, 7, 7, 16'h7FFF);
        push_cmd(mme_pkg::ACT_LOAD_B, 7, 7, 16'h8000);
        push_compute();
        wait_drained();

        // Random phases, each under its own sizes
        phase = 0;
        while (cmds_queued < CMD_TARGET)
        begin
            if (phase == 0)
            begin
                set_size(mme_pkg::REG_ROWS_M, 4'd0);
                set_size(mme_pkg::REG_INNER_K, 4'd15);
                set_size(mme_pkg::REG_COLS_N, 4'd15);
                set_size(mme_pkg::REG_UNUSED, mme_pkg::DIM_W'($urandom));
            end
            else if (phase == 1)
            begin
                set_size(mme_pkg::REG_ROWS_M, 4'd15);
                set_size(mme_pkg::REG_INNER_K, 4'd0);
                set_size(mme_pkg::REG_COLS_N, 4'd0);
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                    if ($urandom_range(0, 2) != 0)
                        set_size(mme_pkg::reg_idx_t'(i), rand_size());
                if ($urandom_range(0, 9) == 0)
                    set_size(mme_pkg::REG_UNUSED, mme_pkg::DIM_W'($urandom));
            end
            m = used_dim(dim_reg[mme_pkg::REG_ROWS_M]);
            k = used_dim(dim_reg[mme_pkg::REG_INNER_K]);
            n = used_dim(dim_reg[mme_pkg::REG_COLS_N]);

            // Load bursts with random content, then a compute
            repeat ($urandom_range(3, 8))
            begin
                repeat ($urandom_range(0, 6))
                begin
                    r = $urandom_range(0, 99);
                    if (r < 8)
                        push_cmd(mme_pkg::ACT_NONE, $urandom_range(0, 7),
                                 $urandom_range(0, 7), mme_pkg::ELEM_W'($urandom));
                    else if (r < 20)
                        push_cmd(r[0] ? mme_pkg::ACT_LOAD_A : mme_pkg::ACT_LOAD_B,
                                 $urandom_range(0, 7), $urandom_range(0, 7), rand_elem());
                    else if (r < 60)
                        push_cmd(mme_pkg::ACT_LOAD_A, $urandom_range(0, m - 1),
                                 $urandom_range(0, k - 1), rand_elem());
                    else
                        push_cmd(mme_pkg::ACT_LOAD_B, $urandom_range(0, k - 1),
                                 $urandom_range(0, n - 1), rand_elem());
                end
                push_compute();
            end
            wait_drained();
            phase++;
        end

        repeat (20) @(posedge clk);
        if (product_fifo.size() != 0)
        begin
            $error("%0d product elements never arrived", product_fifo.size());
            err_count++;
        end
        $display("Run covered %0d loads and %0d computes over %0d size-register writes;",
                 loads_taken, computes_taken, size_writes);
        $display("%0d product elements compared, %0d errors", results_seen, err_count);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
rtl/mme_pkg.sv
rtl/mme_mac.sv
rtl/matrix_multiply_engine_core.sv
rtl/mme_checker.sv
tb/matrix_multiply_engine_core_tb.sv
